### rtl/esc_pkg.sv
// Shared types, constants and shift helpers for the sensor compensation pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIV_W      = 64;
    localparam int FRONT_LAT  = 14;
    localparam int BACK_LAT   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP       = 3'd0,
        REG_PRESS_LOW  = 3'd1,
        REG_PRESS_MID  = 3'd2,
        REG_PRESS_HIGH = 3'd3,
        REG_HUMID_A    = 3'd4,
        REG_HUMID_B    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } t_coef;

    typedef struct packed {
        logic [24:0] temp;
        logic [16:0] hum;
        logic        inv;
    } t_side;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
        return 64'($signed(v) >>> s);
    endfunction

endpackage
`default_nettype wire

### rtl/esc_front.sv
// Temperature, humidity and pressure-divider operand stages of the compensation pipeline.
// Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module esc_front
    import esc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [19:0]   i_at,
    input  wire logic [19:0]   i_ap,
    input  wire logic [15:0]   i_ah,
    input  wire t_coef         i_coef,
    output logic               o_vld,
    output logic [DIV_W-1:0]   o_num,
    output logic [DIV_W-1:0]   o_den,
    output t_side              o_side
);

    logic [FRONT_LAT-1:0] r_v;

    logic [31:0] r1_a, r1_d;
    logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap, r5_ap, r6_ap, r7_ap, r8_ap;
    logic [15:0] r1_ah, r2_ah, r3_ah, r4_ah, r5_ah, r6_ah;
    logic [31:0] r2_m1, r2_dd;
    logic [31:0] r3_v1, r3_m2;
    logic [31:0] r4_tf;
    logic [24:0] r5_temp, r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp;
    logic [24:0] r12_temp, r13_temp, r14_temp;
    logic signed [33:0] r5_w1;
    logic [31:0] r5_x;
    logic [63:0] r6_ww, r6_wp5, r6_wp2;
    logic [31:0] r6_hx5, r6_e2m, r6_e3m;
    logic [63:0] r7_a6, r7_a3, r7_wp5, r7_wp2;
    logic [31:0] r7_e1, r7_e2, r7_e3;
    logic [63:0] r8_w2, r8_w1b;
    logic [31:0] r8_e1, r8_e23;
    logic [63:0] r9_w1c, r9_num0;
    logic [31:0] r9_e1, r9_e4;
    logic [63:0] r10_den, r10_num;
    logic [31:0] r10_e1, r10_e5m;
    logic [63:0] r11_den, r11_num, r12_den, r12_num, r13_den, r13_num, r14_den, r14_num;
    logic [31:0] r11_hx, r12_hx, r13_hx;
    logic [31:0] r12_s2, r13_hy;
    logic [16:0] r14_hum;
    logic        r14_inv;

    logic [31:0] n5_tr;
    logic [31:0] n14_x;
    logic [31:0] n12_s;
    logic [20:0] n9_p;

    always_comb begin
        n5_tr  = asr32(r4_tf * 32'd5 + 32'd128, 8);
        n9_p   = 21'd1048576 - {1'b0, r8_ap};
        n12_s  = asr32(r11_hx, 15);
        n14_x  = r13_hx - asr32(r13_hy, 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FRONT_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a  <= {15'b0, i_at[19:3]} - {15'b0, i_coef.t1, 1'b0};
            r1_d  <= {16'b0, i_at[19:4]} - {16'b0, i_coef.t1};
            r1_ap <= i_ap;
            r1_ah <= i_ah;

            r2_m1 <= r1_a * 32'(i_coef.t2);
            r2_dd <= r1_d * r1_d;
            r2_ap <= r1_ap;
            r2_ah <= r1_ah;

            r3_v1 <= asr32(r2_m1, 11);
            r3_m2 <= asr32(r2_dd, 12) * 32'(i_coef.t3);
            r3_ap <= r2_ap;
            r3_ah <= r2_ah;

            r4_tf <= r3_v1 + asr32(r3_m2, 14);
            r4_ap <= r3_ap;
            r4_ah <= r3_ah;

            if ($signed(n5_tr) < -32'sd16777216) begin
                r5_temp <= 25'h1000000;
            end else if ($signed(n5_tr) > 32'sd16777215) begin
                r5_temp <= 25'h0FFFFFF;
            end else begin
                r5_temp <= n5_tr[24:0];
            end
            r5_w1 <= 34'($signed(r4_tf)) - 34'sd128000;
            r5_x  <= r4_tf - 32'd76800;
            r5_ap <= r4_ap;
            r5_ah <= r4_ah;

            r6_ww   <= 64'(r5_w1) * 64'(r5_w1);
            r6_wp5  <= 64'(r5_w1) * 64'(i_coef.p5);
            r6_wp2  <= 64'(r5_w1) * 64'(i_coef.p2);
            r6_hx5  <= 32'(i_coef.h5) * r5_x;
            r6_e2m  <= r5_x * 32'(i_coef.h6);
            r6_e3m  <= r5_x * {24'b0, i_coef.h3};
            r6_temp <= r5_temp;
            r6_ap   <= r5_ap;
            r6_ah   <= r5_ah;

            r7_a6   <= r6_ww * 64'(i_coef.p6);
            r7_a3   <= r6_ww * 64'(i_coef.p3);
            r7_e1   <= asr32({2'b0, r6_ah, 14'b0} - (32'(i_coef.h4) << 20) - r6_hx5
                             + 32'd16384, 15);
            r7_e2   <= asr32(r6_e2m, 10);
            r7_e3   <= asr32(r6_e3m, 11) + 32'd32768;
            r7_wp5  <= r6_wp5;
            r7_wp2  <= r6_wp2;
            r7_temp <= r6_temp;
            r7_ap   <= r6_ap;

            r8_w2   <= r7_a6 + (r7_wp5 << 17) + (64'(i_coef.p4) << 35);
            r8_w1b  <= asr64(r7_a3, 8) + (r7_wp2 << 12);
            r8_e23  <= r7_e2 * r7_e3;
            r8_e1   <= r7_e1;
            r8_temp <= r7_temp;
            r8_ap   <= r7_ap;

            r9_w1c  <= (64'h0000_8000_0000_0000 + r8_w1b) * {48'b0, i_coef.p1};
            r9_num0 <= ({43'b0, n9_p} << 31) - r8_w2;
            r9_e4   <= asr32(r8_e23, 10) + 32'd2097152;
            r9_e1   <= r8_e1;
            r9_temp <= r8_temp;

            r10_den  <= asr64(r9_w1c, 33);
            r10_num  <= r9_num0 * 64'd3125;
            r10_e5m  <= r9_e4 * 32'(i_coef.h2) + 32'd8192;
            r10_e1   <= r9_e1;
            r10_temp <= r9_temp;

            r11_hx   <= r10_e1 * asr32(r10_e5m, 14);
            r11_num  <= r10_num;
            r11_den  <= r10_den;
            r11_temp <= r10_temp;

            r12_s2   <= n12_s * n12_s;
            r12_hx   <= r11_hx;
            r12_num  <= r11_num;
            r12_den  <= r11_den;
            r12_temp <= r11_temp;

            r13_hy   <= asr32(r12_s2, 7) * {24'b0, i_coef.h1};
            r13_hx   <= r12_hx;
            r13_num  <= r12_num;
            r13_den  <= r12_den;
            r13_temp <= r12_temp;

            if (n14_x[31]) begin
                r14_hum <= '0;
            end else if (n14_x > 32'd419430400) begin
                r14_hum <= 17'd102400;
            end else begin
                r14_hum <= n14_x[28:12];
            end
            r14_inv  <= (r13_den == '0);
            r14_num  <= r13_num;
            r14_den  <= r13_den;
            r14_temp <= r13_temp;
        end
    end

    assign o_vld       = r_v[FRONT_LAT-1];
    assign o_num       = r14_num;
    assign o_den       = r14_den;
    assign o_side.temp = r14_temp;
    assign o_side.hum  = r14_hum;
    assign o_side.inv  = r14_inv;

endmodule
`default_nettype wire

### rtl/esc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
// Depends on esc_pkg; carries the result sideband alongside the quotient.
`timescale 1ns / 1ps
`default_nettype none
module esc_div
    import esc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [DIV_W-1:0] i_num,
    input  wire logic [DIV_W-1:0] i_den,
    input  wire t_side            i_side,
    output logic                  o_vld,
    output logic [DIV_W-1:0]      o_quo,
    output t_side                 o_side
);

    logic [DIV_W-1:0] r_rem  [0:DIV_W];
    logic [DIV_W-1:0] r_qn   [0:DIV_W];
    logic [DIV_W-1:0] r_md   [0:DIV_W];
    logic             r_neg  [0:DIV_W];
    t_side            r_sd   [0:DIV_W];
    logic [DIV_W:0]   r_v;

    logic [DIV_W-1:0] r_quo;
    t_side            r_oside;
    logic             r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_qn[0]  <= i_num[DIV_W-1] ? (~i_num + 1'b1) : i_num;
            if (i_den == '0) begin
                r_md[0] <= DIV_W'(1);
            end else begin
                r_md[0] <= i_den[DIV_W-1] ? (~i_den + 1'b1) : i_den;
            end
            r_neg[0] <= i_num[DIV_W-1] ^ i_den[DIV_W-1];
            r_sd[0]  <= i_side;
        end
    end

    for (genvar j = 0; j < DIV_W; j++) begin : g_step
        logic [DIV_W:0]   trial;
        logic             ge;
        logic [DIV_W:0]   diff;

        always_comb begin
            trial = {r_rem[j], r_qn[j][DIV_W-1]};
            diff  = trial - {1'b0, r_md[j]};
            ge    = ~diff[DIV_W];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                r_qn[j+1]  <= {r_qn[j][DIV_W-2:0], ge};
                r_md[j+1]  <= r_md[j];
                r_neg[j+1] <= r_neg[j];
                r_sd[j+1]  <= r_sd[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[DIV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo   <= r_neg[DIV_W] ? (~r_qn[DIV_W] + 1'b1) : r_qn[DIV_W];
            r_oside <= r_sd[DIV_W];
        end
    end

    assign o_vld  = r_ov;
    assign o_quo  = r_quo;
    assign o_side = r_oside;

endmodule
`default_nettype wire

### rtl/esc_back.sv
// Pressure correction and clamping stages after the divider.
// Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module esc_back
    import esc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [DIV_W-1:0] i_p,
    input  wire t_side            i_side,
    input  wire t_coef            i_coef,
    output logic                  o_vld,
    output logic [31:0]           o_press,
    output t_side                 o_side
);

    logic [BACK_LAT-1:0] r_v;

    logic [63:0] r1_p, r1_ps, r1_pr8;
    logic [63:0] r2_p, r2_ps, r2_q1, r2_r;
    logic [63:0] r3_p, r3_r, r3_ll;
    logic [31:0] r3_mid;
    logic [63:0] r4_sum;
    logic [31:0] r5_press;
    t_side       r1_sd, r2_sd, r3_sd, r4_sd, r5_sd;

    logic [63:0] n4_q2;
    logic [63:0] n5_f;

    always_comb begin
        n4_q2 = r3_ll + {r3_mid, 32'b0};
        n5_f  = asr64(r4_sum, 8) + (64'(i_coef.p7) << 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[BACK_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p   <= i_p;
            r1_ps  <= asr64(i_p, 13);
            r1_pr8 <= i_p * 64'(i_coef.p8);
            r1_sd  <= i_side;

            r2_q1  <= 64'(i_coef.p9) * r1_ps;
            r2_r   <= asr64(r1_pr8, 19);
            r2_p   <= r1_p;
            r2_ps  <= r1_ps;
            r2_sd  <= r1_sd;

            r3_ll  <= {32'b0, r2_q1[31:0]} * {32'b0, r2_ps[31:0]};
            r3_mid <= r2_q1[31:0] * r2_ps[63:32] + r2_q1[63:32] * r2_ps[31:0];
            r3_p   <= r2_p;
            r3_r   <= r2_r;
            r3_sd  <= r2_sd;

            r4_sum <= r3_p + asr64(n4_q2, 25) + r3_r;
            r4_sd  <= r3_sd;

            if (r4_sd.inv || n5_f[63]) begin
                r5_press <= '0;
            end else if (n5_f[62:32] != '0) begin
                r5_press <= '1;
            end else begin
                r5_press <= n5_f[31:0];
            end
            r5_sd <= r4_sd;
        end
    end

    assign o_vld   = r_v[BACK_LAT-1];
    assign o_press = r5_press;
    assign o_side  = r5_sd;

endmodule
`default_nettype wire

### rtl/env_sensor_compensation.sv
// Top level of the sensor compensation block: coefficient registers and stage wiring.
// Depends on esc_pkg, esc_front, esc_div and esc_back.
`timescale 1ns / 1ps
`default_nettype none
// Takes one raw sample per cycle unless the output side stalls and returns one compensated
// result per sample, in order, through 14 stages of temperature, humidity and pressure
// operand arithmetic, 66 stages of the signed 64-bit divider (one quotient bit per stage)
// and 5 pressure correction stages. A stall on the output holds the whole pipeline. Write
// the coefficient registers only while no sample is in flight; they reset to zero.
module env_sensor_compensation
    import esc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
    input  wire logic [55:0]           s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // temperature_centi[24:0], pressure_q24_8[56:25], humidity_q7_10[73:57]
    output logic [79:0]                m_axis_tdata,
    // pressure_invalid[0]
    output logic                       m_axis_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [47:0] r_tc, r_pl, r_pm, r_ph;
    logic [31:0] r_ha, r_hb;
    t_coef       coef;
    logic        en;

    logic             f_vld, d_vld, b_vld;
    logic [DIV_W-1:0] f_num, f_den, d_quo;
    t_side            f_side, d_side, b_side;
    logic [31:0]      b_press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pl <= '0;
            r_pm <= '0;
            r_ph <= '0;
            r_ha <= '0;
            r_hb <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TEMP:       r_tc <= i_cfg_data;
                REG_PRESS_LOW:  r_pl <= i_cfg_data;
                REG_PRESS_MID:  r_pm <= i_cfg_data;
                REG_PRESS_HIGH: r_ph <= i_cfg_data;
                REG_HUMID_A:    r_ha <= i_cfg_data[31:0];
                REG_HUMID_B:    r_hb <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        coef.t1 = r_tc[15:0];
        coef.t2 = r_tc[31:16];
        coef.t3 = r_tc[47:32];
        coef.p1 = r_pl[15:0];
        coef.p2 = r_pl[31:16];
        coef.p3 = r_pl[47:32];
        coef.p4 = r_pm[15:0];
        coef.p5 = r_pm[31:16];
        coef.p6 = r_pm[47:32];
        coef.p7 = r_ph[15:0];
        coef.p8 = r_ph[31:16];
        coef.p9 = r_ph[47:32];
        coef.h1 = r_ha[7:0];
        coef.h2 = r_ha[23:8];
        coef.h3 = r_ha[31:24];
        coef.h4 = r_hb[11:0];
        coef.h5 = r_hb[23:12];
        coef.h6 = r_hb[31:24];
    end

    assign en            = ~b_vld | m_axis_tready;
    assign s_axis_tready = en;

    esc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_at    (s_axis_tdata[19:0]),
        .i_ap    (s_axis_tdata[39:20]),
        .i_ah    (s_axis_tdata[55:40]),
        .i_coef  (coef),
        .o_vld   (f_vld),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    esc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_p     (d_quo),
        .i_side  (d_side),
        .i_coef  (coef),
        .o_vld   (b_vld),
        .o_press (b_press),
        .o_side  (b_side)
    );

    assign m_axis_tvalid = b_vld;
    assign m_axis_tdata  = {6'b0, b_side.hum, b_press, b_side.temp};
    assign m_axis_tuser  = b_side.inv;

endmodule
`default_nettype wire

### bench/tb_env_sensor_compensation.sv
// Self-checking testbench for env_sensor_compensation: random and directed raw samples,
// idle and stall phases, coefficient sets from zero to extremes. Depends on esc_pkg and the RTL.
`timescale 1ns / 1ps

class comp_scoreboard;
    typedef struct packed {
        logic [24:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
        logic        inv;
    } t_comp;

    bit [47:0] tc, pl, pm, ph;
    bit [31:0] ha, hb;
    t_comp     expected_q[$];
    int        errors;

    function void set_coeff(bit [2:0] idx, bit [47:0] val);
        case (idx)
            esc_pkg::REG_TEMP:       tc = val;
            esc_pkg::REG_PRESS_LOW:  pl = val;
            esc_pkg::REG_PRESS_MID:  pm = val;
            esc_pkg::REG_PRESS_HIGH: ph = val;
            esc_pkg::REG_HUMID_A:    ha = val[31:0];
            esc_pkg::REG_HUMID_B:    hb = val[31:0];
            default: ;
        endcase
    endfunction

    function bit [31:0] shr32(bit [31:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function bit [63:0] shr64(bit [63:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function t_comp compensate(bit [55:0] raw);
        bit [31:0] at, ah, t1, t2, t3, a, v1, d, v2, tf, tr;
        bit [31:0] h1, h2, h3, h4, h5, h6, x, e1, e2, e3, e4, e5, s;
        bit [63:0] ap, p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, q, r, num, mn, md, qq;
        longint    tv;
        t_comp     res;
        at = raw[19:0];
        ap = raw[39:20];
        ah = raw[55:40];
        t1 = tc[15:0];
        t2 = 32'($signed(tc[31:16]));
        t3 = 32'($signed(tc[47:32]));
        a  = (at >> 3) - (t1 << 1);
        v1 = shr32(a * t2, 11);
        d  = (at >> 4) - t1;
        v2 = shr32(shr32(d * d, 12) * t3, 14);
        tf = v1 + v2;
        tr = shr32(tf * 32'd5 + 32'd128, 8);
        tv = longint'($signed(tr));
        if (tv < -16777216) tv = -16777216;
        if (tv > 16777215) tv = 16777215;
        res.temp = tv[24:0];

        p1 = pl[15:0];
        p2 = 64'($signed(pl[31:16]));
        p3 = 64'($signed(pl[47:32]));
        p4 = 64'($signed(pm[15:0]));
        p5 = 64'($signed(pm[31:16]));
        p6 = 64'($signed(pm[47:32]));
        p7 = 64'($signed(ph[15:0]));
        p8 = 64'($signed(ph[31:16]));
        p9 = 64'($signed(ph[47:32]));
        w1 = 64'($signed(tf)) - 64'd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) << 17);
        w2 = w2 + (p4 << 35);
        w1 = shr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = shr64(((64'd1 << 47) + w1) * p1, 33);
        if (w1 == 0) begin
            res.press = 0;
            res.inv   = 1'b1;
        end else begin
            p   = 64'd1048576 - ap;
            num = ((p << 31) - w2) * 64'd3125;
            mn  = num[63] ? -num : num;
            md  = w1[63] ? -w1 : w1;
            qq  = mn / md;
            p   = (num[63] != w1[63]) ? -qq : qq;
            q   = shr64(p9 * shr64(p, 13) * shr64(p, 13), 25);
            r   = shr64(p8 * p, 19);
            p   = shr64(p + q + r, 8) + (p7 << 4);
            if (p[63]) res.press = 0;
            else if (p > 64'hFFFF_FFFF) res.press = 32'hFFFF_FFFF;
            else res.press = p[31:0];
            res.inv = 1'b0;
        end

        h1 = ha[7:0];
        h2 = 32'($signed(ha[23:8]));
        h3 = ha[31:24];
        h4 = 32'($signed(hb[11:0]));
        h5 = 32'($signed(hb[23:12]));
        h6 = 32'($signed(hb[31:24]));
        x  = tf - 32'd76800;
        e1 = shr32((ah << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
        e2 = shr32(x * h6, 10);
        e3 = shr32(x * h3, 11) + 32'd32768;
        e4 = shr32(e2 * e3, 10) + 32'd2097152;
        e5 = shr32(e4 * h2 + 32'd8192, 14);
        x  = e1 * e5;
        s  = shr32(x, 15);
        x  = x - shr32(shr32(s * s, 7) * h1, 4);
        if (x[31]) x = 0;
        if (x > 32'd419430400) x = 32'd419430400;
        res.hum = x[28:12];
        return res;
    endfunction

    function void note_sample(bit [55:0] raw);
        expected_q.push_back(compensate(raw));
    endfunction

    function void check_result(bit [79:0] data, bit inv);
        t_comp want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result tdata=%h tuser=%b", $time, data, inv);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (data[24:0] !== want.temp) begin
            $display("%0t: temperature expected %h actual %h", $time, want.temp, data[24:0]);
            errors++;
        end
        if (data[56:25] !== want.press) begin
            $display("%0t: pressure expected %h actual %h", $time, want.press, data[56:25]);
            errors++;
        end
        if (data[73:57] !== want.hum) begin
            $display("%0t: humidity expected %h actual %h", $time, want.hum, data[73:57]);
            errors++;
        end
        if (inv !== want.inv) begin
            $display("%0t: pressure_invalid expected %b actual %b", $time, want.inv, inv);
            errors++;
        end
    endfunction
endclass

module tb_env_sensor_compensation;
    import esc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = FRONT_LAT + DIV_W + 2 + BACK_LAT + 20;
    localparam int STALL_LIMIT  = 5000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [79:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    comp_scoreboard sb = new();
    int tx_idle_pct;
    int rx_stall_pct;
    int quiet_cycles = 0;

    env_sensor_compensation i_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_sample(bit [55:0] raw);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(raw);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, bit [47:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_coeff(idx, val);
    endtask

    task automatic load_coeffs(int set);
        bit [47:0] v [6];
        case (set)
            0: v = '{{16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
                     {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500},
                     {16'h0, 8'd0, 16'd362, 8'd75}, {16'h0, 8'd30, 12'd50, 12'd313}};
            1: v = '{default: 48'hFFFF_FFFF_FFFF};
            2: v = '{default: 48'h8000_7FFF_8000};
            3: v = '{default: 48'h7FFF_8000_FFFF};
            default: foreach (v[k]) v[k] = 48'({$urandom, $urandom});
        endcase
        if (set >= 4 && set % 2 == 0) begin
            v[0] = {16'(int'($urandom_range(1999)) - 1000),
                    16'($urandom_range(30000, 24000)),
                    16'($urandom_range(30000, 25000))};
        end
        cfg_write(REG_TEMP, v[0]);
        cfg_write(REG_PRESS_LOW, v[1]);
        cfg_write(REG_PRESS_MID, v[2]);
        cfg_write(REG_PRESS_HIGH, v[3]);
        cfg_write(REG_HUMID_A, v[4]);
        cfg_write(REG_HUMID_B, v[5]);
        if (set == 2) cfg_write(IDX_UNUSED, 48'h1234_5678_9ABC);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_directed();
        send_sample('0);
        send_sample('1);
        send_sample({16'd0, 20'd0, 20'hFFFFF});
        send_sample({16'd0, 20'hFFFFF, 20'd0});
        send_sample({16'hFFFF, 20'd0, 20'd0});
        send_sample({16'hAAAA, 20'h55555, 20'hAAAAA});
        send_sample({16'h5555, 20'hAAAAA, 20'h55555});
        send_sample({16'd30000, 20'd415148, 20'd519888});
    endtask

    task automatic send_random(int n);
        bit [55:0] raw;
        repeat (n) begin
            if ($urandom_range(99) < 60)
                raw = {16'($urandom_range(45000, 15000)), 20'($urandom_range(500000, 230000)),
                       20'($urandom_range(620000, 380000))};
            else
                raw = 56'({$urandom, $urandom});
            send_sample(raw);
        end
    endtask

    initial begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero coefficients: pressure divisor is zero
        send_directed();
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            load_coeffs(ph);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase
            if (ph < 4) send_directed();
            send_random(45);
            if (ph == 2) drain();
            send_random(45);
        end
        drain();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
